// ----- hw/rtl/bst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg: shared types and constants of the bitmap slot table
// Opcodes, status codes, field widths and the command record passed from the
// front end to the executor.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int SLOTS     = 256;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int MAX_BYTES = 8;
    localparam int DATA_W    = 64;
    localparam int WORD_W    = 64;
    localparam int WORDS     = SLOTS / WORD_W;
    localparam int WSEL_W    = $clog2(WORDS);
    localparam int WBIT_W    = $clog2(WORD_W);
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [3:0] {
        OP_PUT     = 4'd0,
        OP_SET     = 4'd1,
        OP_SET_TRY = 4'd2,
        OP_GET     = 4'd3,
        OP_REMOVE  = 4'd4,
        OP_FIRST   = 4'd5,
        OP_NEXT    = 4'd6,
        OP_PREV    = 4'd7,
        OP_LAST    = 4'd8
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SIZE  = 3'd1,
        ST_INDEX = 3'd2,
        ST_NONE  = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    // classified command from the front end
    typedef enum logic [2:0] {
        K_DONE,     // result settled up front (error or unused opcode)
        K_PUT,
        K_WRITE,    // set / set_try, checks on the map left to executor
        K_READ,     // get / remove
        K_SCAN_UP,
        K_SCAN_DOWN
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              is_try;
        logic              is_remove;
        logic              size_bad;
        logic              up_empty;   // scan range empty from the start
        t_status           status;
        logic [IDX_W-1:0]  idx;        // target or scan bound
        logic [3:0]        nbytes;
        logic [DATA_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] rdata;
        logic [CNT_W-1:0]  count;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_RWAIT,
        S_DONE
    } t_exec_state;

    function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] n);
        logic [DATA_W-1:0] m;
        m = '0;
        for (int b = 0; b < MAX_BYTES; b++) begin
            if (4'(b) < n) begin
                m[b*8 +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/bst_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_front: command intake
// Decodes an input transaction, does the checks that need no table state and
// pushes a command record into a small queue toward the executor.
// ----------------------------------------------------------------------------
module bst_front
    import bst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [3:0]        i_opcode,
    input  logic [IDX_W-1:0]  i_slot_index,
    input  logic [3:0]        i_byte_count,
    input  logic [DATA_W-1:0] i_write_data,
    input  logic [3:0]        i_eff_size,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output t_cmd              o_cmd
);

    t_cmd  r_q [FIFO_DEPTH];
    logic  r_wp, r_rp;
    logic  [1:0] r_cnt;
    t_cmd  n_cmd;
    logic  push, pop;

    always_comb begin
        n_cmd           = '0;
        n_cmd.idx       = i_slot_index;
        n_cmd.nbytes    = i_byte_count;
        n_cmd.data      = i_write_data;
        n_cmd.size_bad  = i_byte_count > i_eff_size;
        n_cmd.status    = ST_OK;
        n_cmd.kind      = K_DONE;
        unique case (i_opcode)
            OP_PUT: begin
                if (n_cmd.size_bad) n_cmd.status = ST_SIZE;
                else                n_cmd.kind   = K_PUT;
            end
            OP_SET, OP_SET_TRY: begin
                n_cmd.is_try = (i_opcode == OP_SET_TRY);
                if (!n_cmd.is_try && n_cmd.size_bad) n_cmd.status = ST_SIZE;
                else                                 n_cmd.kind   = K_WRITE;
            end
            OP_GET, OP_REMOVE: begin
                n_cmd.is_remove = (i_opcode == OP_REMOVE);
                n_cmd.kind      = K_READ;
            end
            OP_FIRST: begin
                n_cmd.kind = K_SCAN_UP;
                n_cmd.idx  = '0;
            end
            OP_NEXT: begin
                n_cmd.kind     = K_SCAN_UP;
                n_cmd.idx      = i_slot_index + 1'b1;
                n_cmd.up_empty = (i_slot_index == IDX_W'(SLOTS - 1));
            end
            OP_PREV: begin
                // search below idx; idx 0 finds nothing
                n_cmd.kind     = K_SCAN_DOWN;
                n_cmd.idx      = i_slot_index - 1'b1;
                n_cmd.up_empty = (i_slot_index == '0);
            end
            OP_LAST: begin
                n_cmd.kind = K_SCAN_DOWN;
                n_cmd.idx  = IDX_W'(SLOTS - 1);
            end
            default: ;
        endcase
    end

    assign o_ready     = (r_cnt != 2'(FIFO_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- hw/rtl/bst_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_exec: table executor
// Holds the occupancy map, element store and live count. Scans walk the map
// one 64-bit word per cycle with a priority encoder, then read the store.
// ----------------------------------------------------------------------------
module bst_exec
    import bst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  t_cmd              i_cmd,
    input  logic [3:0]        i_eff_size,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    logic [SLOTS-1:0]  r_map;
    logic [DATA_W-1:0] r_mem [SLOTS];
    logic [DATA_W-1:0] r_rdq;
    logic [CNT_W-1:0]  r_count;
    t_exec_state       r_state, n_state;
    t_cmd              r_cmd;
    logic [WSEL_W-1:0] r_wsel;
    logic              r_found;
    logic [IDX_W-1:0]  r_hit;
    t_result           r_res;
    logic              r_res_valid;

    // per-word search
    logic [WORD_W-1:0] word, cand;
    logic              w_hit;
    logic [WBIT_W-1:0] w_pos;
    logic              up;
    logic [WSEL_W-1:0] bound_w;
    logic [WBIT_W-1:0] bound_b;
    logic              last_word;

    assign up      = (r_cmd.kind == K_SCAN_UP) || (r_cmd.kind == K_PUT);
    assign bound_w = r_cmd.idx[IDX_W-1 -: WSEL_W];
    assign bound_b = r_cmd.idx[WBIT_W-1:0];
    assign word    = r_map[r_wsel*WORD_W +: WORD_W];

    always_comb begin
        cand = (r_cmd.kind == K_PUT) ? ~word : word;
        if (r_cmd.kind != K_PUT && r_wsel == bound_w) begin
            for (int b = 0; b < WORD_W; b++) begin
                if (up ? (WBIT_W'(b) < bound_b) : (WBIT_W'(b) > bound_b)) begin
                    cand[b] = 1'b0;
                end
            end
        end
        w_hit = |cand;
        w_pos = '0;
        if (up) begin
            for (int b = WORD_W - 1; b >= 0; b--) begin
                if (cand[b]) w_pos = WBIT_W'(b);
            end
        end else begin
            for (int b = 0; b < WORD_W; b++) begin
                if (cand[b]) w_pos = WBIT_W'(b);
            end
        end
        last_word = up ? (r_wsel == WSEL_W'(WORDS - 1)) : (r_wsel == '0);
    end

    // a new command starts only once the previous result is handed off
    assign o_cmd_ready = (r_state == S_IDLE) && (!r_res_valid || i_res_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_cmd_valid && o_cmd_ready) n_state = S_SCAN;
            S_SCAN: begin
                if (r_cmd.kind == K_PUT || r_cmd.kind == K_SCAN_UP ||
                    r_cmd.kind == K_SCAN_DOWN) begin
                    if (r_cmd.up_empty)           n_state = S_READ;
                    else if (w_hit || last_word)  n_state = S_READ;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_RWAIT;
            S_RWAIT: n_state = S_DONE;
            S_DONE:  if (!r_res_valid || i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan walker
    always_ff @(posedge i_clk) begin
        if (o_cmd_ready && i_cmd_valid) begin
            r_cmd   <= i_cmd;
            r_found <= 1'b0;
            r_hit   <= '0;
            if (i_cmd.kind == K_PUT || i_cmd.kind == K_SCAN_UP) begin
                r_wsel <= (i_cmd.kind == K_PUT) ? '0 : i_cmd.idx[IDX_W-1 -: WSEL_W];
            end else begin
                r_wsel <= i_cmd.idx[IDX_W-1 -: WSEL_W];
            end
        end else if (r_state == S_SCAN) begin
            if (w_hit && !r_found) begin
                r_found <= 1'b1;
                r_hit   <= {r_wsel, w_pos};
            end
            if (!w_hit && !last_word) begin
                r_wsel <= up ? r_wsel + 1'b1 : r_wsel - 1'b1;
            end
        end
    end

    // store read, registered
    logic [IDX_W-1:0] rd_addr;
    assign rd_addr = (r_cmd.kind == K_READ || r_cmd.kind == K_WRITE) ? r_cmd.idx : r_hit;

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rdq <= r_mem[rd_addr];
        end
    end

    // decide result and commit in S_RWAIT
    logic              occ;
    logic [DATA_W-1:0] wmask;
    assign occ   = r_map[r_cmd.idx];
    assign wmask = byte_mask(r_cmd.nbytes);

    always_ff @(posedge i_clk) begin
        if (r_state == S_RWAIT) begin
            if (r_cmd.kind == K_PUT && r_found) begin
                r_mem[r_hit] <= (r_rdq & ~wmask) | (r_cmd.data & wmask);
            end else if (r_cmd.kind == K_WRITE && !(r_cmd.is_try && occ) &&
                         !r_cmd.size_bad) begin
                r_mem[r_cmd.idx] <= (r_rdq & ~wmask) | (r_cmd.data & wmask);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;
            if (r_state == S_RWAIT) begin
                case (r_cmd.kind)
                    K_PUT: if (r_found) begin
                        r_map[r_hit] <= 1'b1;
                        r_count      <= r_count + 1'b1;
                    end
                    K_WRITE: if (!(r_cmd.is_try && occ) && !r_cmd.size_bad && !occ) begin
                        r_map[r_cmd.idx] <= 1'b1;
                        r_count          <= r_count + 1'b1;
                    end
                    K_READ: if (occ && r_cmd.is_remove) begin
                        r_map[r_cmd.idx] <= 1'b0;
                        r_count          <= r_count - 1'b1;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!r_res_valid || i_res_ready)) begin
                r_res_valid <= 1'b1;
            end
        end
    end

    // result formation, register stage beside the commit
    t_result res_c;
    always_comb begin
        res_c        = '0;
        res_c.status = ST_OK;
        unique case (r_cmd.kind)
            K_DONE:  res_c.status = r_cmd.status;
            K_PUT: begin
                if (r_found) res_c.index = r_hit;
                else         res_c.status = ST_FULL;
            end
            K_WRITE: begin
                if (r_cmd.is_try && occ) res_c.status = ST_NONE;
                else if (r_cmd.size_bad) res_c.status = ST_SIZE;
            end
            K_READ: begin
                if (!occ) res_c.status = ST_NONE;
                else      res_c.rdata  = r_rdq & byte_mask(i_eff_size);
            end
            K_SCAN_UP, K_SCAN_DOWN: begin
                if (!r_found || r_cmd.up_empty) begin
                    res_c.status = ST_NONE;
                end else begin
                    res_c.index = r_hit;
                    res_c.rdata = r_rdq & byte_mask(i_eff_size);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RWAIT) begin
            r_res <= res_c;
        end
    end

    assign o_res_valid = r_res_valid;
    always_comb begin
        o_res       = r_res;
        o_res.count = r_count;
    end

endmodule

// ----- hw/rtl/bitmap_slot_table_core.sv -----
`timescale 1ns / 1ps
// put and scans step through the 64-bit map words (at most 4), then read the store.
// the executor takes the next command once the previous result is accepted, with a
// 2-entry queue in front.
// the bitmap and live count clear on synchronous reset; the element store
// holds no reset value. element_bytes resets to 8.
// ----------------------------------------------------------------------------
// bitmap_slot_table_core: slot table top level
// Stream intake, command queue and table executor with a result register.
// ----------------------------------------------------------------------------
module bitmap_slot_table_core
    import bst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // opcode[3:0] slot_index[11:4]
                                       // byte_count[15:12] write_data[79:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata   // status[2:0] result_index[10:3]
                                       // read_data[74:11] live_count[83:75]
);

    logic [3:0] r_elem_bytes;
    logic [3:0] eff_size;
    logic       cmd_valid, cmd_ready;
    t_cmd       cmd;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_bytes <= 4'd8;
        end else if (i_cfg_we) begin
            r_elem_bytes <= i_cfg_wdata;
        end
    end

    assign eff_size = (r_elem_bytes > 4'(MAX_BYTES)) ? 4'(MAX_BYTES) : r_elem_bytes;

    bst_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tdata[3:0]),
        .i_slot_index (s_axis_tdata[11:4]),
        .i_byte_count (s_axis_tdata[15:12]),
        .i_write_data (s_axis_tdata[79:16]),
        .i_eff_size   (eff_size),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    bst_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_eff_size  (eff_size),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {4'b0, res.count, res.rdata, res.index, res.status};

endmodule
